### hdl/lgs_pkg.sv
// Shared constants and the query token type for the least-greater-successor chain.
`default_nettype none

package lgs_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int VAL_W     = 31;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One query travels down the chain as this token, one cell per cycle while the chain is not frozen.
  typedef struct packed {
    logic valid;
    val_t value;   // the queried element
    val_t carry;   // element still looking for its place
    logic found;
    val_t succ;
    logic ovf;     // table was full: nothing is inserted
    cnt_t cnt;     // entries held for this array when the item entered
  } lgs_tok_t;

endpackage

`default_nettype wire

### hdl/lgs_cell.sv
// One storage cell of the sorted chain: holds one entry and updates the passing token.
`default_nettype none

module lgs_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire lgs_pkg::cnt_t     cell_idx,
  input  wire lgs_pkg::lgs_tok_t tok_in,
  output lgs_pkg::lgs_tok_t      tok_out
);
  import lgs_pkg::*;

  val_t     entry_r;
  val_t     entry_nxt;
  lgs_tok_t tok_r;
  lgs_tok_t tok_nxt;

  logic occ;
  logic place;
  logic swap;

  // Entries sit as a prefix of the chain, so the count in the token tells
  // whether this cell holds live data for the token's view of the table.
  always_comb begin
    occ   = cell_idx < tok_in.cnt;
    place = !tok_in.ovf && (cell_idx == tok_in.cnt);
    swap  = !tok_in.ovf && occ && (entry_r > tok_in.carry);

    tok_nxt   = tok_in;
    entry_nxt = entry_r;
    if (tok_in.valid) begin
      if (!tok_in.found && occ && (entry_r > tok_in.value)) begin
        tok_nxt.found = 1'b1;
        tok_nxt.succ  = entry_r;
      end
      if (place || swap) begin
        entry_nxt = tok_in.carry;
      end
      if (swap) begin
        tok_nxt.carry = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r.valid <= tok_nxt.valid;
    end
    if (adv) begin
      entry_r     <= entry_nxt;
      tok_r.value <= tok_nxt.value;
      tok_r.carry <= tok_nxt.carry;
      tok_r.found <= tok_nxt.found;
      tok_r.succ  <= tok_nxt.succ;
      tok_r.ovf   <= tok_nxt.ovf;
      tok_r.cnt   <= tok_nxt.cnt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

### hdl/least_greater_successor_core.sv
// Top level of the least-greater-successor block: entry logic, cell chain and result register.
//
// Array elements enter on the in_ channel from the rightmost element to the
// leftmost; in_last_of_array marks the leftmost one. For every element one
// result leaves on the out_ channel: the smallest earlier element of the same
// array that is strictly greater (out_found, out_successor, zero when not
// found) and out_overflow when the table already held MAX_ITEMS entries.
// Each item travels down a chain of MAX_ITEMS cells, one cell per cycle while
// the chain is not frozen, inserting itself in order as it passes; the last
// cell feeds a result register that drives the out_ channel. A new item can
// be taken every cycle unless in_stall is high.
// When out_stall holds a pending result, the whole chain freezes and in_stall
// rises in the same cycle; nothing is lost or reordered.
// Synchronous reset empties the pipeline and the table count; cell contents
// need no clearing because the count decides which cells are live.
`default_nettype none

module least_greater_successor_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [30:0]         in_value,
  input  wire logic                in_last_of_array,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_found,
  output logic [30:0]              out_successor,
  output logic                     out_overflow
);
  import lgs_pkg::*;

  lgs_tok_t tok_w [MAX_ITEMS+1];

  cnt_t cnt_r;
  cnt_t cnt_nxt;
  logic full;
  logic adv;
  logic in_xfer;

  logic out_valid_r;
  logic out_found_r;
  val_t out_succ_r;
  logic out_ovf_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;
  assign full     = cnt_r == cnt_t'(MAX_ITEMS);

  always_comb begin
    tok_w[0].valid = in_valid;
    tok_w[0].value = in_value;
    tok_w[0].carry = in_value;
    tok_w[0].found = 1'b0;
    tok_w[0].succ  = '0;
    tok_w[0].ovf   = full;
    tok_w[0].cnt   = cnt_r;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      if (in_last_of_array) begin
        cnt_nxt = '0;
      end else if (!full) begin
        cnt_nxt = cnt_r + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    lgs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cell_idx(cnt_t'(g)),
      .tok_in  (tok_w[g]),
      .tok_out (tok_w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok_w[MAX_ITEMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_found_r <= tok_w[MAX_ITEMS].found;
      out_succ_r  <= tok_w[MAX_ITEMS].succ;
      out_ovf_r   <= tok_w[MAX_ITEMS].ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_successor = out_succ_r;
  assign out_overflow  = out_ovf_r;

endmodule

`default_nettype wire

### hdl/lgs_checker.sv
// Port-level checks for the least-greater-successor block and their bind to the top level.
`default_nettype none

module lgs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_found,
  input wire logic [30:0] out_successor,
  input wire logic        out_overflow
);

  // A stalled result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
    $stable(out_successor) && $stable(out_overflow))
    else $error("stalled result changed");

  // A not-found answer carries a zero successor.
  a_succ_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_successor == 31'd0)
    else $error("successor not zero without a match");

  // The input side only stalls because a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind least_greater_successor_core lgs_checker u_lgs_checker (.*);

`default_nettype wire
